@@ hdl/clws_pkg.sv @@
package clws_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_CMD    = 2'd0,
    OP_CHAR   = 2'd1,
    OP_CURSOR = 2'd2
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_BUS_MODE   = 2'd0;
  localparam logic [1:0] REG_PHASE_HOLD = 2'd1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HOLD_W     = 16;
  localparam int unsigned BYTE_W     = 8;

  // bus mode codes
  localparam logic MODE_8BIT = 1'b0;
  localparam logic MODE_4BIT = 1'b1;

  localparam logic [7:0] SET_ADDR_CMD = 8'h80;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // last phase number of a write in each bus mode
  localparam logic [2:0] LAST_PH_8BIT = 3'd3;
  localparam logic [2:0] LAST_PH_4BIT = 3'd6;

  // one classified write waiting for the pin sequencer
  typedef struct packed {
    logic       rs;
    logic [7:0] val;
  } wr_entry_t;

  // display address offset of each row
  function automatic logic [7:0] row_offset(input logic [1:0] row);
    logic [7:0] off;
    case (row)
      2'd0:    off = 8'h00;
      2'd1:    off = 8'h40;
      2'd2:    off = 8'h10;
      default: off = 8'h50;
    endcase
    return off;
  endfunction

endpackage

@@ hdl/clws_req_if.sv @@
interface clws_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] byte_value;
  logic [1:0] row;
  logic [3:0] column;

  modport source (output valid, opcode, byte_value, row, column, input ready);
  modport sink   (input valid, opcode, byte_value, row, column, output ready);
endinterface

@@ hdl/clws_phase_if.sv @@
interface clws_phase_if;
  logic        valid;
  logic        ready;
  logic        rs_level;
  logic        enable_level;
  logic [7:0]  bus_value;
  logic [15:0] hold_count;
  logic        last_phase;

  modport source (output valid, rs_level, enable_level, bus_value, hold_count, last_phase,
                  input ready);
  modport sink   (input valid, rs_level, enable_level, bus_value, hold_count, last_phase,
                  output ready);
endinterface

@@ hdl/clws_cfg_if.sv @@
interface clws_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/clws_front.sv @@
module clws_front (
  clws_req_if.sink           req,
  input  logic               q_ready,
  output logic               q_push,
  output clws_pkg::wr_entry_t q_data
);
  import clws_pkg::*;

  logic       known;
  logic [7:0] addr;

  // cursor move becomes set-address command
  assign addr = ({4'b0000, req.column} + row_offset(req.row)) | SET_ADDR_CMD;

  // classify request into rs level and byte
  always_comb begin
    known      = 1'b1;
    q_data.rs  = 1'b0;
    q_data.val = req.byte_value;
    case (op_t'(req.opcode))
      OP_CMD: begin
        q_data.rs  = 1'b0;
        q_data.val = req.byte_value;
      end
      OP_CHAR: begin
        q_data.rs  = 1'b1;
        q_data.val = req.byte_value;
      end
      OP_CURSOR: begin
        q_data.rs  = 1'b0;
        q_data.val = addr;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown codes are taken and dropped
  assign req.ready = q_ready;
  assign q_push    = req.valid && q_ready && known;

endmodule

@@ hdl/clws_queue.sv @@
module clws_queue #(
  parameter int unsigned DEPTH = clws_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  clws_pkg::wr_entry_t push_data,
  output logic                not_full,
  input  logic                pop,
  output logic                not_empty,
  output clws_pkg::wr_entry_t head
);
  import clws_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wr_entry_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign not_full  = (count_r != CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/clws_back.sv @@
module clws_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                bus_mode,
  input  logic [15:0]         phase_hold,
  input  logic                q_valid,
  input  clws_pkg::wr_entry_t q_head,
  output logic                q_pop,
  clws_phase_if.source        phase
);
  import clws_pkg::*;

  logic        busy_r, busy_nxt;
  logic [2:0]  ph_r, ph_nxt;
  wr_entry_t   cur_r;
  logic [7:0]  bus_level_r;
  logic        out_valid_r;
  logic        out_rs_r, out_en_r, out_last_r;
  logic [7:0]  out_bus_r;
  logic [15:0] out_hold_r;

  logic        emit, is_last, en_val;
  logic [7:0]  bus_val;
  logic [15:0] hold_val;

  // one phase per cycle while a write is in progress and the output register is free
  assign emit    = busy_r && (!out_valid_r || phase.ready);
  assign is_last = (bus_mode == MODE_4BIT) ? (ph_r == LAST_PH_4BIT) : (ph_r == LAST_PH_8BIT);
  assign q_pop   = q_valid && (!busy_r || (emit && is_last));
  assign hold_val = (phase_hold == '0) ? 16'd1 : phase_hold;

  // pin levels of the current phase
  always_comb begin
    en_val  = 1'b0;
    bus_val = bus_level_r;
    if (bus_mode == MODE_4BIT) begin
      case (ph_r)
        3'd0: en_val = 1'b0;
        3'd1: en_val = 1'b1;
        3'd2: begin en_val = 1'b1; bus_val = {4'b0000, cur_r.val[7:4]}; end
        3'd3: begin en_val = 1'b0; bus_val = {4'b0000, cur_r.val[7:4]}; end
        3'd4: begin en_val = 1'b1; bus_val = {4'b0000, cur_r.val[7:4]}; end
        3'd5: begin en_val = 1'b1; bus_val = {4'b0000, cur_r.val[3:0]}; end
        3'd6: begin en_val = 1'b0; bus_val = {4'b0000, cur_r.val[3:0]}; end
        default: en_val = 1'b0;
      endcase
    end else begin
      case (ph_r)
        3'd0: en_val = 1'b0;
        3'd1: en_val = 1'b1;
        3'd2: begin en_val = 1'b1; bus_val = cur_r.val; end
        3'd3: begin en_val = 1'b0; bus_val = cur_r.val; end
        default: en_val = 1'b0;
      endcase
    end
  end

  // sequencer control
  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      ph_nxt   = '0;
    end else if (emit) begin
      busy_nxt = !is_last;
      ph_nxt   = ph_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ph_r        <= '0;
      out_valid_r <= 1'b0;
      bus_level_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
        bus_level_r <= bus_val;
      end else if (phase.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and output payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
    if (emit) begin
      out_rs_r   <= cur_r.rs;
      out_en_r   <= en_val;
      out_bus_r  <= bus_val;
      out_hold_r <= hold_val;
      out_last_r <= is_last;
    end
  end

  assign phase.valid        = out_valid_r;
  assign phase.rs_level     = out_rs_r;
  assign phase.enable_level = out_en_r;
  assign phase.bus_value    = out_bus_r;
  assign phase.hold_count   = out_hold_r;
  assign phase.last_phase   = out_last_r;

endmodule

@@ hdl/char_lcd_write_sequencer.sv @@
// Character-LCD write sequencer. Each request (command byte, display character or
// cursor move) produces the pin phases of one write on out_phase, one phase per
// cycle while the receiver is ready: 4 phases in 8-bit mode, 7 in 4-bit mode, set
// by the phase sequencer in the back end. Requests are classified in the front
// end and wait in a small queue (QUEUE_DEPTH entries), so new requests are taken
// while a write is still going out. Unknown opcodes are taken and dropped.
// Configuration writes are always accepted and must happen only while no write
// is pending. A hold of zero is reported as one.
module char_lcd_write_sequencer #(
  parameter int unsigned QUEUE_DEPTH = clws_pkg::QUEUE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  clws_req_if.sink     in_req,
  clws_phase_if.source out_phase,
  clws_cfg_if.sink     cfg_wr
);
  import clws_pkg::*;

  logic        bus_mode_r;
  logic [15:0] phase_hold_r;
  logic        q_push, q_pop, q_not_full, q_not_empty;
  wr_entry_t   q_in, q_head;

  // configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_mode_r   <= MODE_8BIT;
      phase_hold_r <= 16'd1;
    end else if (cfg_wr.valid) begin
      if (cfg_wr.index == REG_BUS_MODE) begin
        bus_mode_r <= cfg_wr.data[0];
      end else if (cfg_wr.index == REG_PHASE_HOLD) begin
        phase_hold_r <= cfg_wr.data;
      end
    end
  end

  clws_front u_front (
    .req     (in_req),
    .q_ready (q_not_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  clws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  clws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bus_mode   (bus_mode_r),
    .phase_hold (phase_hold_r),
    .q_valid    (q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .phase      (out_phase)
  );

endmodule

@@ hdl/clws_checker.sv @@
module clws_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_enable,
  input logic        out_last,
  input logic [7:0]  out_bus,
  input logic [15:0] out_hold
);

  // reset empties the output
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // stalled phase holds its pins
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bus) && $stable(out_enable)
      && $stable(out_last))
    else $error("stalled phase changed");

  // hold count is never zero
  a_hold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hold != 16'd0)
    else $error("zero hold count");

  // a write ends with enable low
  a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !out_enable)
    else $error("last phase with enable high");

endmodule

bind char_lcd_write_sequencer clws_checker u_clws_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_phase.valid),
  .out_ready  (out_phase.ready),
  .out_enable (out_phase.enable_level),
  .out_last   (out_phase.last_phase),
  .out_bus    (out_phase.bus_value),
  .out_hold   (out_phase.hold_count)
);

@@ bench/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import clws_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYC  = 24;
  localparam int unsigned HOLD_OFF    = 300;
  localparam int unsigned PHASE_ITEMS = 56;

  // one pin phase as the block reports it
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [7:0] bus;
    logic [15:0] hold;
    logic       last;
  } pin_phase_t;

  // one directed request with its bus configuration
  typedef struct packed {
    logic        mode;
    logic [15:0] hold;
    logic [1:0]  op;
    logic [7:0]  byte_val;
    logic [1:0]  row;
    logic [3:0]  col;
    logic        chk;
    logic [7:0]  fin_bus;
  } dir_row_t;

  // typed-in final bus value of a write
  typedef struct packed {
    logic       chk;
    logic [7:0] bus;
  } fin_bus_t;

  localparam int unsigned DIR_N = 23;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{MODE_8BIT, 16'd1,     OP_CMD,    8'h00, 2'd0, 4'd0,  1'b1, 8'h00},
    '{MODE_8BIT, 16'd1,     OP_CMD,    8'hFF, 2'd0, 4'd0,  1'b1, 8'hFF},
    '{MODE_8BIT, 16'd1,     OP_CHAR,   8'h00, 2'd0, 4'd0,  1'b1, 8'h00},
    '{MODE_8BIT, 16'd1,     OP_CHAR,   8'hFF, 2'd0, 4'd0,  1'b1, 8'hFF},
    '{MODE_8BIT, 16'd1,     OP_CHAR,   8'hA5, 2'd3, 4'd15, 1'b1, 8'hA5},
    '{MODE_8BIT, 16'd1,     OP_CURSOR, 8'hFF, 2'd0, 4'd0,  1'b1, 8'h80},
    '{MODE_8BIT, 16'd1,     OP_CURSOR, 8'h00, 2'd1, 4'd15, 1'b1, 8'hCF},
    '{MODE_8BIT, 16'd1,     OP_CURSOR, 8'h3C, 2'd2, 4'd5,  1'b1, 8'h95},
    '{MODE_8BIT, 16'd1,     OP_CURSOR, 8'h00, 2'd3, 4'd15, 1'b1, 8'hDF},
    '{MODE_8BIT, 16'd1,     OP_UNUSED, 8'hFF, 2'd3, 4'd15, 1'b0, 8'h00},
    '{MODE_8BIT, 16'd1,     OP_CHAR,   8'h5A, 2'd0, 4'd0,  1'b1, 8'h5A},
    '{MODE_8BIT, 16'd0,     OP_CMD,    8'h38, 2'd0, 4'd0,  1'b1, 8'h38},
    '{MODE_8BIT, 16'd0,     OP_CHAR,   8'h41, 2'd2, 4'd9,  1'b1, 8'h41},
    '{MODE_4BIT, 16'hFFFF,  OP_CMD,    8'h28, 2'd0, 4'd0,  1'b1, 8'h08},
    '{MODE_4BIT, 16'hFFFF,  OP_CHAR,   8'hFF, 2'd0, 4'd0,  1'b1, 8'h0F},
    '{MODE_4BIT, 16'hFFFF,  OP_CHAR,   8'h00, 2'd3, 4'd15, 1'b1, 8'h00},
    '{MODE_4BIT, 16'hFFFF,  OP_CURSOR, 8'h00, 2'd3, 4'd15, 1'b1, 8'h0F},
    '{MODE_4BIT, 16'hFFFF,  OP_CURSOR, 8'hFF, 2'd0, 4'd0,  1'b1, 8'h00},
    '{MODE_4BIT, 16'hFFFF,  OP_UNUSED, 8'h00, 2'd0, 4'd0,  1'b0, 8'h00},
    '{MODE_4BIT, 16'hFFFF,  OP_CMD,    8'hF0, 2'd0, 4'd0,  1'b1, 8'h00},
    '{MODE_4BIT, 16'd0,     OP_CHAR,   8'h7E, 2'd0, 4'd0,  1'b1, 8'h0E},
    '{MODE_8BIT, 16'hFFFF,  OP_CMD,    8'h01, 2'd0, 4'd0,  1'b1, 8'h01},
    '{MODE_8BIT, 16'd1,     OP_CHAR,   8'h80, 2'd1, 4'd3,  1'b1, 8'h80}
  };

  // display address base of each row
  localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h10, 8'h50};

  logic clk;
  logic rst_n;

  clws_req_if   req_if();
  clws_phase_if ph_if();
  clws_cfg_if   cfg_if();

  char_lcd_write_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (req_if),
    .out_phase (ph_if),
    .cfg_wr    (cfg_if)
  );

  // predictor state and configuration copy
  logic        mode_cfg;
  logic [15:0] hold_cfg;
  logic [7:0]  bus_pins;

  pin_phase_t pin_phase_q [$];
  fin_bus_t   fin_bus_q [$];
  int         mismatches;
  bit         calm;
  bit         hold_off_pending;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("%0t timeout with %0d phases outstanding", $realtime, pin_phase_q.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // expected pin phases of one write request
  function automatic void plan_write(input logic [1:0] op, input logic [7:0] byte_val,
                                     input logic [1:0] row, input logic [3:0] col);
    logic        rs;
    logic [7:0]  val;
    logic [15:0] hold;
    if (op == OP_UNUSED) return;
    rs   = (op == OP_CHAR);
    val  = (op == OP_CURSOR) ? ((ROW_BASE[row] + {4'd0, col}) | SET_ADDR_CMD) : byte_val;
    hold = (hold_cfg == 16'd0) ? 16'd1 : hold_cfg;
    pin_phase_q.push_back('{rs, 1'b0, bus_pins, hold, 1'b0});
    pin_phase_q.push_back('{rs, 1'b1, bus_pins, hold, 1'b0});
    if (mode_cfg == MODE_8BIT) begin
      bus_pins = val;
      pin_phase_q.push_back('{rs, 1'b1, bus_pins, hold, 1'b0});
      pin_phase_q.push_back('{rs, 1'b0, bus_pins, hold, 1'b1});
    end else begin
      bus_pins = {4'd0, val[7:4]};
      pin_phase_q.push_back('{rs, 1'b1, bus_pins, hold, 1'b0});
      pin_phase_q.push_back('{rs, 1'b0, bus_pins, hold, 1'b0});
      pin_phase_q.push_back('{rs, 1'b1, bus_pins, hold, 1'b0});
      bus_pins = {4'd0, val[3:0]};
      pin_phase_q.push_back('{rs, 1'b1, bus_pins, hold, 1'b0});
      pin_phase_q.push_back('{rs, 1'b0, bus_pins, hold, 1'b1});
    end
  endfunction

  // idle cycles before the next request or phase
  function automatic int unsigned pick_wait();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %h actual %h", $realtime, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // issue one request and record its expected phases on acceptance
  task automatic send_request(input logic [1:0] op, input logic [7:0] byte_val,
                              input logic [1:0] row, input logic [3:0] col,
                              input logic chk, input logic [7:0] fin_bus);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.byte_value <= byte_val;
    req_if.row        <= row;
    req_if.column     <= col;
    do @(posedge clk); while (!req_if.ready);
    plan_write(op, byte_val, row, col);
    if (op != OP_UNUSED) fin_bus_q.push_back('{chk, fin_bus});
  endtask

  // wait for all expected phases, then let any dropped request clear
  task automatic settle_writes();
    req_if.valid <= 1'b0;
    while (pin_phase_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // write both registers back to back with valid held high
  task automatic set_config(input logic mode, input logic [15:0] hold);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_BUS_MODE;
    cfg_if.data  <= {15'd0, mode};
    do @(posedge clk); while (!cfg_if.ready);
    mode_cfg = mode;
    cfg_if.index <= REG_PHASE_HOLD;
    cfg_if.data  <= hold;
    do @(posedge clk); while (!cfg_if.ready);
    hold_cfg = hold;
    cfg_if.valid <= 1'b0;
  endtask

  // phase receiver with random stalls and one long hold-off
  initial begin
    int unsigned stall;
    pin_phase_t  act;
    pin_phase_t  exp_ph;
    fin_bus_t    fin;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = pick_wait();
      if (hold_off_pending) begin
        stall = HOLD_OFF;
        hold_off_pending = 1'b0;
      end
      if (stall > 0) begin
        ph_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      ph_if.ready <= 1'b1;
      do @(posedge clk); while (ph_if.valid !== 1'b1);
      act = '{ph_if.rs_level, ph_if.enable_level, ph_if.bus_value, ph_if.hold_count,
              ph_if.last_phase};
      if (pin_phase_q.size() == 0) begin
        $display("%0t unexpected phase expected none actual %h", $realtime, act);
        mismatches++;
      end else begin
        exp_ph = pin_phase_q.pop_front();
        check_field("rs_level", 16'(exp_ph.rs), 16'(act.rs));
        check_field("enable_level", 16'(exp_ph.en), 16'(act.en));
        check_field("bus_value", 16'(exp_ph.bus), 16'(act.bus));
        check_field("hold_count", exp_ph.hold, act.hold);
        check_field("last_phase", 16'(exp_ph.last), 16'(act.last));
      end
      // typed-in final data of directed writes
      if (act.last === 1'b1 && fin_bus_q.size() != 0) begin
        fin = fin_bus_q.pop_front();
        if (fin.chk) check_field("final bus_value", 16'(fin.bus), 16'(act.bus));
      end
    end
  end

  // stimulus
  initial begin
    logic        ph_mode [6];
    logic [15:0] ph_hold [6];
    logic [1:0]  op;
    int unsigned sent;
    req_if.valid      <= 1'b0;
    req_if.opcode     <= OP_CMD;
    req_if.byte_value <= 8'd0;
    req_if.row        <= 2'd0;
    req_if.column     <= 4'd0;
    ph_if.ready       <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= REG_BUS_MODE;
    cfg_if.data       <= 16'd0;
    rst_n             <= 1'b0;
    mismatches        = 0;
    calm              = 1'b0;
    hold_off_pending  = 1'b0;
    mode_cfg          = MODE_8BIT;
    hold_cfg          = 16'd1;
    bus_pins          = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reconfiguring when a row asks for other settings
    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].mode != mode_cfg || DIR_TAB[i].hold != hold_cfg) begin
        settle_writes();
        set_config(DIR_TAB[i].mode, DIR_TAB[i].hold);
      end
      send_request(DIR_TAB[i].op, DIR_TAB[i].byte_val, DIR_TAB[i].row, DIR_TAB[i].col,
                   DIR_TAB[i].chk, DIR_TAB[i].fin_bus);
    end

    // random phases over several bus settings
    ph_mode = '{MODE_8BIT, MODE_4BIT, MODE_4BIT, MODE_8BIT, MODE_4BIT, MODE_8BIT};
    ph_hold = '{16'hFFFF, 16'd1, 16'($urandom_range(2, 65534)), 16'd0, 16'hFFFF,
                16'($urandom_range(0, 65535))};
    for (int p = 0; p < 6; p++) begin
      settle_writes();
      set_config(ph_mode[p], ph_hold[p]);
      calm = (p == 3);
      // receiver stalls long so the request queue backs up
      if (p == 2) hold_off_pending = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        op = ($urandom_range(0, 9) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
        send_request(op, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                     4'($urandom_range(0, 15)), 1'b0, 8'd0);
        if (op != OP_UNUSED) sent++;
      end
    end

    settle_writes();
    calm = 1'b0;
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/clws_pkg.sv
hdl/clws_req_if.sv
hdl/clws_phase_if.sv
hdl/clws_cfg_if.sv
hdl/clws_front.sv
hdl/clws_queue.sv
hdl/clws_back.sv
hdl/char_lcd_write_sequencer.sv
hdl/clws_checker.sv
bench/testbench.sv
